// ===== sv/ple_pkg.sv =====
package ple_pkg;

    // Fixed field widths of the request and result transactions.
    localparam int ACT_W   = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 6;

    // Depth of the request queue between front and back.
    localparam int QDEPTH  = 2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

    // Request operations, encoded as the action field.
    typedef enum logic [ACT_W-1:0] {
        OP_ADD_FRONT = 3'd0,
        OP_ADD_BACK  = 3'd1,
        OP_INSERT_AT = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_LIST      = 3'd6,
        OP_NONE      = 3'd7
    } t_op;

    // Classified request as it travels through the queue.
    typedef struct packed {
        t_op                        op;
        logic signed [VALUE_W-1:0]  value;
        logic [POS_W-1:0]           position;
        logic [POS_W-1:0]           pos_m1;
        logic                       pos_zero;
    } t_req;

endpackage

// ===== sv/ple_front.sv =====
module ple_front (
    input  logic [ple_pkg::ACT_W-1:0]          i_action,
    input  logic signed [ple_pkg::VALUE_W-1:0] i_value,
    input  logic [ple_pkg::POS_W-1:0]          i_position,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_q_full,
    output logic                               o_push,
    output ple_pkg::t_req                      o_req
);
    import ple_pkg::*;

    // Accept a transaction whenever the queue has room.
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // Classify the request and precompute the 0-based position.
    always_comb begin
        o_req.op       = t_op'(i_action);
        o_req.value    = i_value;
        o_req.position = i_position;
        o_req.pos_m1   = i_position - POS_W'(1);
        o_req.pos_zero = (i_position == '0);
    end

endmodule

// ===== sv/ple_queue.sv =====
module ple_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ple_pkg::t_req i_data,
    output logic          o_full,
    output logic          o_valid,
    output ple_pkg::t_req o_data,
    input  logic          i_pop
);
    import ple_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int NW = $clog2(QDEPTH + 1);

    t_req            r_mem [QDEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [NW-1:0]   r_num;
    logic [PW-1:0]   n_wr;
    logic [PW-1:0]   n_rd;
    logic [NW-1:0]   n_num;

    assign o_full  = (r_num == NW'(QDEPTH));
    assign o_valid = (r_num != '0);
    assign o_data  = r_mem[r_rd];

    // Pointer and occupancy update with wrap at the queue depth.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_num = r_num;
        if (i_push) begin
            n_wr = (r_wr == PW'(QDEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(QDEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_num = r_num + NW'(1);
        end else if (i_pop && !i_push) begin
            n_num = r_num - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_num <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_num <= n_num;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== sv/ple_back.sv =====
module ple_back #(
    parameter int CAPACITY = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_req_valid,
    input  ple_pkg::t_req                      i_req,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [ple_pkg::STAT_W-1:0]         o_status,
    output logic [ple_pkg::CNT_W-1:0]          o_element_count,
    output logic signed [ple_pkg::VALUE_W-1:0] o_element_value,
    output logic                               o_last
);
    import ple_pkg::*;

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LIST = 2'b10
    } t_bstate;

    logic signed [VALUE_W-1:0] r_cells [CAPACITY];
    logic signed [VALUE_W-1:0] n_cells [CAPACITY];
    logic [LW-1:0]             r_len;
    logic [LW-1:0]             n_len;
    logic [LW-1:0]             r_cnt;
    logic [LW-1:0]             n_cnt;
    t_bstate                   r_state;
    t_bstate                   n_state;
    logic                      r_ov;
    logic                      n_ov;
    logic [STAT_W-1:0]         r_status;
    logic [STAT_W-1:0]         n_status;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;
    logic                      r_last;
    logic                      n_last;

    logic                      out_free;
    logic                      pop;
    logic                      do_ins;
    logic                      do_del;
    logic                      do_rot;
    logic [CW-1:0]             p;
    logic [CW-1:0]             len_ext;
    logic [CW-1:0]             pos_ext;
    logic                      full;

    assign out_free = !r_ov || i_out_ready;
    assign pop      = out_free && (r_state == S_IDLE) && i_req_valid;
    assign o_pop    = pop;
    assign len_ext  = CW'(r_len);
    assign pos_ext  = CW'(i_req.position);
    assign full     = (r_len == LW'(CAPACITY));

    // Execute one request, or stream the next listed element: status, new length and the result transaction.
    always_comb begin
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_state  = r_state;
        n_ov     = r_ov && !i_out_ready;
        n_status = r_status;
        n_count  = r_count;
        n_value  = r_value;
        n_last   = r_last;
        do_ins   = 1'b0;
        do_del   = 1'b0;
        do_rot   = 1'b0;
        p        = '0;

        if (pop) begin
            n_ov     = 1'b1;
            n_status = ST_OK;
            n_value  = '0;
            n_last   = 1'b1;
            case (i_req.op)
                OP_ADD_FRONT, OP_ADD_BACK: begin
                    p = (i_req.op == OP_ADD_BACK) ? len_ext : '0;
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        do_ins = 1'b1;
                    end
                end
                OP_INSERT_AT: begin
                    p = CW'(i_req.pos_m1);
                    if (i_req.pos_zero || (pos_ext > len_ext + CW'(1))) begin
                        n_status = ST_BADPOS;
                    end else if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        do_ins = 1'b1;
                    end
                end
                OP_DEL_FRONT: begin
                    if (r_len == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        do_del = 1'b1;
                    end
                end
                OP_DEL_BACK: begin
                    if (r_len == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_len = r_len - LW'(1);
                    end
                end
                OP_DEL_AT: begin
                    p = CW'(i_req.pos_m1);
                    if (i_req.pos_zero || (pos_ext > len_ext)) begin
                        n_status = ST_BADPOS;
                    end else begin
                        do_del = 1'b1;
                    end
                end
                OP_LIST: begin
                    if (r_len == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        // First element goes out now, the rest one per cycle while results are taken.
                        n_value = r_cells[0];
                        n_last  = (r_len == LW'(1));
                        do_rot  = 1'b1;
                        if (r_len != LW'(1)) begin
                            n_state = S_LIST;
                            n_cnt   = LW'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
            if (do_ins) begin
                n_len = r_len + LW'(1);
            end
            if (do_del) begin
                n_len = r_len - LW'(1);
            end
            n_count = CNT_W'(n_len);
        end else if ((r_state == S_LIST) && out_free) begin
            // Stream the element now at the head while rotating the list.
            n_ov     = 1'b1;
            n_status = ST_OK;
            n_value  = r_cells[0];
            n_count  = CNT_W'(r_len);
            n_last   = (CW'(r_cnt) + CW'(1) == len_ext);
            n_cnt    = r_cnt + LW'(1);
            do_rot   = 1'b1;
            if (n_last) begin
                n_state = S_IDLE;
            end
        end
    end

    // Shifting cells: insert moves the tail up, delete moves it down, and
    // listing rotates the occupied part by one so the list returns intact.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_cells[i] = r_cells[i];
        end
        if (do_ins) begin
            for (int i = 1; i < CAPACITY; i++) begin
                if ((CW'(i) > p) && (CW'(i) <= len_ext)) begin
                    n_cells[i] = r_cells[i-1];
                end
            end
            for (int i = 0; i < CAPACITY; i++) begin
                if (CW'(i) == p) begin
                    n_cells[i] = i_req.value;
                end
            end
        end
        if (do_del) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                if ((CW'(i) >= p) && (CW'(i) + CW'(1) < len_ext)) begin
                    n_cells[i] = r_cells[i+1];
                end
            end
        end
        if (do_rot) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                if (CW'(i) + CW'(1) < len_ext) begin
                    n_cells[i] = r_cells[i+1];
                end
            end
            for (int i = 0; i < CAPACITY; i++) begin
                if (CW'(i) + CW'(1) == len_ext) begin
                    n_cells[i] = r_cells[0];
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_cnt   <= '0;
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    // Element cells and result payload.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            r_cells[i] <= n_cells[i];
        end
        r_status <= n_status;
        r_count  <= n_count;
        r_value  <= n_value;
        r_last   <= n_last;
    end

    assign o_out_valid     = r_ov;
    assign o_status        = r_status;
    assign o_element_count = r_count;
    assign o_element_value = r_value;
    assign o_last          = r_last;

    // The element count never goes past the capacity.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(CAPACITY))
        else $error("element count above capacity");

    // Listing only runs over a list of two or more elements, with at least
    // one element still to emit.
    a_list_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> (r_cnt < r_len) && (r_cnt != '0))
        else $error("listing counter out of range");

    // The list length holds while a listing is in progress.
    a_list_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |=> (r_len == $past(r_len)))
        else $error("length changed during listing");

    // No new request is taken while a listing is in progress.
    a_no_pop_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> !pop)
        else $error("request popped during listing");

endmodule

// ===== sv/positional_list_engine.sv =====
// Positional list engine: holds an ordered list of up to CAPACITY signed
// 32-bit values and executes add front/back, insert at a 1-based position,
// delete front/back, delete at a position and list all. A front stage
// classifies each input transaction into a two-entry queue, and a back stage
// executes it on a row of shifting cells. Every insert or delete gives one
// result with status and element count. List all gives one result per
// element, one per cycle while results are taken, with the final one marked
// by o_last; an empty list gives a single result with status "list empty".
// Sustained rate is one request per cycle while results are taken; a list
// all occupies the back stage until its last element has been emitted.
// Results wait in an output register, and the queue takes up to two more
// requests meanwhile. Rejected requests leave the list unchanged.
module positional_list_engine #(
    parameter int CAPACITY = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [ple_pkg::ACT_W-1:0]          i_action,
    input  logic signed [ple_pkg::VALUE_W-1:0] i_value,
    input  logic [ple_pkg::POS_W-1:0]          i_position,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [ple_pkg::STAT_W-1:0]         o_status,
    output logic [ple_pkg::CNT_W-1:0]          o_element_count,
    output logic signed [ple_pkg::VALUE_W-1:0] o_element_value,
    output logic                               o_last
);
    import ple_pkg::*;

    t_req  push_req;
    t_req  q_req;
    logic  push;
    logic  q_full;
    logic  q_valid;
    logic  pop;

    ple_front u_front (
        .i_action   (i_action),
        .i_value    (i_value),
        .i_position (i_position),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_req      (push_req)
    );

    ple_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_req),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_req),
        .i_pop   (pop)
    );

    ple_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (q_valid),
        .i_req           (q_req),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_element_count (o_element_count),
        .o_element_value (o_element_value),
        .o_last          (o_last)
    );

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;

    localparam int CAPACITY   = 32;
    localparam int N_RANDOM   = 200;
    localparam int HOLD_TICKS = 300;
    localparam int DRAIN_WAIT = 40;

    // One result transaction as the block emits it.
    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic [CNT_W-1:0]          count;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_result;

    // One row of the directed table; typed rows carry a hand-written result.
    typedef struct packed {
        t_op                       op;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
        logic                      typed;
        logic [STAT_W-1:0]         status;
        logic [CNT_W-1:0]          count;
    } t_row;

    logic                      i_clk           = 1'b0;
    logic                      i_rst_n         = 1'b0;
    logic                      i_in_valid      = 1'b0;
    logic [ACT_W-1:0]          i_action        = '0;
    logic signed [VALUE_W-1:0] i_value         = '0;
    logic [POS_W-1:0]          i_position      = '0;
    logic                      i_out_ready     = 1'b0;
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic [STAT_W-1:0]         o_status;
    logic [CNT_W-1:0]          o_element_count;
    logic signed [VALUE_W-1:0] o_element_value;
    logic                      o_last;

    // Shadow copy of the list, and the results still owed by the block.
    logic signed [VALUE_W-1:0] shadow_list [CAPACITY+1];
    int unsigned               shadow_len = 0;
    t_result                   pending_results [$];

    t_row                      directed_rows [0:23];

    int  error_count    = 0;
    int  results_seen   = 0;
    int  requests_sent  = 0;
    int  full_rejects   = 0;
    int  max_len_seen   = 0;
    bit  no_idle        = 1'b0;
    bit  hold_request   = 1'b0;

    positional_list_engine #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_value         (i_value),
        .i_position      (i_position),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_element_count (o_element_count),
        .o_element_value (o_element_value),
        .o_last          (o_last)
    );

    always #1 i_clk = ~i_clk;

    // Insert into the shadow list at a 0-based index, shifting the tail up.
    function automatic logic [STAT_W-1:0] shadow_insert(int unsigned idx,
                                                        logic signed [VALUE_W-1:0] v);
        if (shadow_len >= CAPACITY) begin
            full_rejects++;
            return ST_FULL;
        end
        for (int i = shadow_len; i > idx; i--) begin
            shadow_list[i] = shadow_list[i-1];
        end
        shadow_list[idx] = v;
        shadow_len++;
        if (shadow_len > max_len_seen) begin
            max_len_seen = shadow_len;
        end
        return ST_OK;
    endfunction

    // Remove the element at a 0-based index, shifting the tail down.
    function automatic void shadow_remove(int unsigned idx);
        for (int i = idx; i + 1 < shadow_len; i++) begin
            shadow_list[i] = shadow_list[i+1];
        end
        shadow_len--;
    endfunction

    // Apply one request to the shadow list and queue the results it owes.
    function automatic void predict_list_op(t_op op, logic signed [VALUE_W-1:0] v,
                                            logic [POS_W-1:0] pos);
        logic [STAT_W-1:0] st;
        st = ST_OK;
        case (op)
            OP_ADD_FRONT: st = shadow_insert(0, v);
            OP_ADD_BACK:  st = shadow_insert(shadow_len, v);
            OP_INSERT_AT: begin
                if (pos < 1 || pos > shadow_len + 1) begin
                    st = ST_BADPOS;
                end else begin
                    st = shadow_insert(pos - 1, v);
                end
            end
            OP_DEL_FRONT: begin
                if (shadow_len == 0) begin
                    st = ST_EMPTY;
                end else begin
                    shadow_remove(0);
                end
            end
            OP_DEL_BACK: begin
                if (shadow_len == 0) begin
                    st = ST_EMPTY;
                end else begin
                    shadow_len--;
                end
            end
            OP_DEL_AT: begin
                if (pos < 1 || pos > shadow_len) begin
                    st = ST_BADPOS;
                end else begin
                    shadow_remove(pos - 1);
                end
            end
            OP_LIST: begin
                if (shadow_len == 0) begin
                    st = ST_EMPTY;
                end else begin
                    for (int i = 0; i < shadow_len; i++) begin
                        pending_results.push_back('{ST_OK, CNT_W'(shadow_len),
                                                   shadow_list[i], (i + 1 == shadow_len)});
                    end
                    return;
                end
            end
            default: st = ST_OK;
        endcase
        pending_results.push_back('{st, CNT_W'(shadow_len), '0, 1'b1});
    endfunction

    // Offer one request transaction, with an occasional random gap in front, until accepted.
    task automatic send_request(input t_op op, input logic signed [VALUE_W-1:0] v,
                                input logic [POS_W-1:0] pos, input logic typed,
                                input logic [STAT_W-1:0] st, input logic [CNT_W-1:0] cnt);
        int gap;
        int depth_before;
        gap = 0;
        if (!no_idle && $urandom_range(99) < 15) begin
            gap = $urandom_range(1, 4);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= op;
        i_value    <= v;
        i_position <= pos;
        do @(posedge i_clk); while (!o_in_ready);
        requests_sent++;
        // The shadow list always advances; a typed row replaces the predicted result.
        depth_before = pending_results.size();
        predict_list_op(op, v, pos);
        if (typed) begin
            while (pending_results.size() > depth_before) begin
                void'(pending_results.pop_back());
            end
            pending_results.push_back('{st, cnt, '0, 1'b1});
        end
    endtask

    // Pick an operation; mode 0 grows the list, 1 mixes, 2 drains it.
    function automatic t_op choose_op(int mode);
        int r;
        int add_lim;
        int del_lim;
        r = $urandom_range(99);
        add_lim = (mode == 0) ? 85 : (mode == 1) ? 45 : 12;
        del_lim = (mode == 0) ? 93 : (mode == 1) ? 85 : 90;
        if (r < add_lim) begin
            case ($urandom_range(2))
                0:       return OP_ADD_FRONT;
                1:       return OP_ADD_BACK;
                default: return OP_INSERT_AT;
            endcase
        end else if (r < del_lim) begin
            case ($urandom_range(2))
                0:       return OP_DEL_FRONT;
                1:       return OP_DEL_BACK;
                default: return OP_DEL_AT;
            endcase
        end else if (r < 98) begin
            return OP_LIST;
        end
        return OP_NONE;
    endfunction

    // Mostly legal positions for the positional operations, sometimes anything.
    function automatic logic [POS_W-1:0] choose_pos(t_op op);
        if (op == OP_INSERT_AT && $urandom_range(99) < 80) begin
            return POS_W'($urandom_range(1, shadow_len + 1));
        end
        if (op == OP_DEL_AT && shadow_len > 0 && $urandom_range(99) < 80) begin
            return POS_W'($urandom_range(1, shadow_len));
        end
        return POS_W'($urandom_range(0, 63));
    endfunction

    function automatic logic signed [VALUE_W-1:0] choose_value();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'shFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Compare each accepted result transaction with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result status=%0d count=%0d value=%0d last=%0d",
                         $realtime, o_status, o_element_count, o_element_value, o_last);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    error_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, want.status, o_status);
                end
                if (o_element_count !== want.count) begin
                    error_count++;
                    $display("%0t: element_count expected %0d actual %0d",
                             $realtime, want.count, o_element_count);
                end
                if (o_element_value !== want.value) begin
                    error_count++;
                    $display("%0t: element_value expected %0d actual %0d",
                             $realtime, want.value, o_element_value);
                end
                if (o_last !== want.last) begin
                    error_count++;
                    $display("%0t: last expected %0d actual %0d",
                             $realtime, want.last, o_last);
                end
            end
        end
    end

    // Result side: random back-pressure, one long hold-off on request.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && hold_request) begin
                hold_left = HOLD_TICKS;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (no_idle) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= 15);
            end
        end
    end

    // Request side: reset, directed table, then phased random traffic.
    initial begin
        t_op op;
        int  mode;
        directed_rows = '{
            '{OP_DEL_FRONT, 32'sd0,          6'd0,  1'b1, ST_EMPTY,  6'd0},
            '{OP_DEL_BACK,  32'sd0,          6'd0,  1'b1, ST_EMPTY,  6'd0},
            '{OP_LIST,      32'sd0,          6'd0,  1'b1, ST_EMPTY,  6'd0},
            '{OP_DEL_AT,    32'sd0,          6'd1,  1'b1, ST_BADPOS, 6'd0},
            '{OP_DEL_AT,    32'sd0,          6'd0,  1'b1, ST_BADPOS, 6'd0},
            '{OP_INSERT_AT, 32'sd5,          6'd0,  1'b1, ST_BADPOS, 6'd0},
            '{OP_INSERT_AT, 32'sd5,          6'd2,  1'b1, ST_BADPOS, 6'd0},
            '{OP_NONE,      32'sd9,          6'd0,  1'b1, ST_OK,     6'd0},
            '{OP_INSERT_AT, 32'sh7FFF_FFFF,  6'd1,  1'b1, ST_OK,     6'd1},
            '{OP_DEL_BACK,  32'sd0,          6'd0,  1'b1, ST_OK,     6'd0},
            '{OP_LIST,      32'sd0,          6'd0,  1'b1, ST_EMPTY,  6'd0},
            '{OP_ADD_FRONT, 32'sh8000_0000,  6'd0,  1'b1, ST_OK,     6'd1},
            '{OP_ADD_BACK,  32'shFFFF_FFFF,  6'd0,  1'b1, ST_OK,     6'd2},
            '{OP_ADD_FRONT, 32'sd0,          6'd0,  1'b1, ST_OK,     6'd3},
            '{OP_INSERT_AT, 32'sd1,          6'd63, 1'b1, ST_BADPOS, 6'd3},
            '{OP_INSERT_AT, 32'sh5555_5555,  6'd4,  1'b0, ST_OK,     6'd0},
            '{OP_INSERT_AT, 32'shAAAA_AAAA,  6'd2,  1'b0, ST_OK,     6'd0},
            '{OP_LIST,      32'sd0,          6'd0,  1'b0, ST_OK,     6'd0},
            '{OP_DEL_AT,    32'sd0,          6'd63, 1'b1, ST_BADPOS, 6'd5},
            '{OP_DEL_AT,    32'sd0,          6'd5,  1'b0, ST_OK,     6'd0},
            '{OP_DEL_AT,    32'sd0,          6'd1,  1'b0, ST_OK,     6'd0},
            '{OP_DEL_FRONT, 32'sd0,          6'd0,  1'b0, ST_OK,     6'd0},
            '{OP_LIST,      32'sd0,          6'd0,  1'b0, ST_OK,     6'd0},
            '{OP_NONE,      32'sh7FFF_FFFF,  6'd63, 1'b0, ST_OK,     6'd0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            send_request(directed_rows[k].op, directed_rows[k].value,
                         directed_rows[k].position, directed_rows[k].typed,
                         directed_rows[k].status, directed_rows[k].count);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            // Grow to capacity, mix, grow again, then drain to empty.
            mode = (n < 60) ? 0 : (n < 100) ? 1 : (n < 150) ? 0 : 2;
            if (n == 20) begin
                hold_request = 1'b1;
            end
            no_idle = (n >= 60 && n < 100);
            if (n == 100) begin
                // Let the block drain completely before carrying on.
                i_in_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            op = choose_op(mode);
            send_request(op, choose_value(), choose_pos(op), 1'b0, ST_OK, '0);
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Ran %0d requests and checked %0d results; the list reached %0d entries",
                 requests_sent, results_seen, max_len_seen);
        $display("and %0d adds were turned away by a full list.", full_rejects);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #400_000;
        $display("%0t: timeout with %0d results outstanding",
                 $realtime, pending_results.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
